>>> design/ira_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_pkg
// Shared constants, codes and controller/datapath interface types for the
// ID range allocator.
// -----------------------------------------------------------------------------
package ira_pkg;

    localparam int ID_BITS     = 16;
    localparam int RANGE_SLOTS = 16;
    localparam int SLOT_BITS   = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int COUNT_BITS  = $clog2(RANGE_SLOTS + 1);
    localparam int SUM_BITS    = COUNT_BITS + 1;

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STS_ALLOCATED   = 2'd0,
        STS_ALLOC_FAIL  = 2'd1,
        STS_FREED       = 2'd2,
        STS_FREE_DROP   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ALLOC_CHK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // capture request
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;       // read slot at head + idx
        logic    fresh_inc;
        logic    fresh_lower;
        logic    pop;         // drop oldest range
        logic    bump;        // oldest range first += 1
        logic    grow_down;   // scanned range first = id
        logic    grow_up;     // scanned range last = id
        logic    append;      // new one-ID range at tail
        logic    resp;        // load output register
        logic    grant_ring;  // granted comes from the oldest range
        status_t resp_status;
    } ira_cmd_t;

    // datapath -> controller
    typedef struct packed {
        func_t func;
        logic  out_free;
        logic  ring_empty;
        logic  ring_full;
        logic  at_limit;
        logic  lower_hit;
        logic  head_single;
        logic  match_down;
        logic  match_up;
        logic  scan_end;
    } ira_stat_t;

    // (base + off) mod RANGE_SLOTS, base < RANGE_SLOTS, off <= RANGE_SLOTS
    function automatic slot_t slot_add(input slot_t base, input count_t off);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(off);
        if (sum >= SUM_BITS'(RANGE_SLOTS))
        begin
            sum = sum - SUM_BITS'(RANGE_SLOTS);
        end
        return sum[SLOT_BITS-1:0];
    endfunction

endpackage

>>> design/id_range_allocator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// id_range_allocator
// Allocates and frees numeric IDs from a fresh counter and a ring of free
// ID ranges.
// -----------------------------------------------------------------------------
// One request per transfer on the s_ side, one result per request on the m_
// side, in order. Allocate takes the first ID of the oldest free range (the
// range is dropped once empty); with no ranges it takes the fresh counter
// (reset 1) and fails when the counter equals id_limit. Free lowers the
// counter when the ID sits just below it, else grows the oldest range that
// borders the ID, else appends a one-ID range; with the ring full the free is
// dropped (status 3). Ranges are never merged. Timing: requests are handled
// one at a time by the sequencer, with the range storage read through a
// registered port. An allocate from the ring reads the oldest range before
// it grants; a free that does not lower the counter reads and compares the
// ranges from the oldest one on until one borders the ID or the last one is
// done, and then appends or drops. The result waits in an output register,
// so a new request is taken while the last result is still pending; a
// request only stalls when its result is due and the last one is untaken.
// The user must write id_limit through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it.
// -----------------------------------------------------------------------------
module id_range_allocator
    import ira_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ID_BITS-1:0] s_tdata,   // [15:0] free_value
    input  logic [0:0]         s_tuser,   // [0] func (0 allocate, 1 free)
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ID_BITS-1:0] m_tdata,   // [15:0] granted
    output logic [1:0]         m_tuser,   // [1:0] status
    // id_limit register
    input  logic               cfg_we,
    input  logic [ID_BITS-1:0] cfg_wdata
);

    ira_cmd_t  cmd;
    ira_stat_t stat;

    // sequencer: one request at a time
    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // counter, range ring, compares and output register
    ira_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> design/ira_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_ctrl
// Sequencer for the ID range allocator: decides each request, walks the range
// ring for frees, and issues datapath commands.
// -----------------------------------------------------------------------------
module ira_ctrl
    import ira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ira_stat_t stat,
    output ira_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.func == FUNC_ALLOC)
                begin
                    if (!stat.ring_empty)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_ALLOC_CHK;
                    end
                    else if (stat.out_free)
                    begin
                        cmd.resp = 1'b1;
                        if (stat.at_limit)
                        begin
                            cmd.resp_status = STS_ALLOC_FAIL;
                        end
                        else
                        begin
                            cmd.resp_status = STS_ALLOCATED;
                            cmd.fresh_inc   = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (stat.lower_hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.fresh_lower = 1'b1;
                        cmd.resp        = 1'b1;
                        cmd.resp_status = STS_FREED;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.ring_empty)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_ALLOC_CHK:
            begin
                if (stat.out_free)
                begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = STS_ALLOCATED;
                    cmd.grant_ring  = 1'b1;
                    cmd.pop         = stat.head_single;
                    cmd.bump        = !stat.head_single;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                // first == id+1 wins over last == id-1 in the same slot
                if (stat.match_down || stat.match_up)
                begin
                    if (stat.out_free)
                    begin
                        cmd.grow_down   = stat.match_down;
                        cmd.grow_up     = !stat.match_down;
                        cmd.resp        = 1'b1;
                        cmd.resp_status = STS_FREED;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.scan_end)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_APPEND:
            begin
                if (stat.out_free)
                begin
                    cmd.resp = 1'b1;
                    if (stat.ring_full)
                    begin
                        cmd.resp_status = STS_FREE_DROP;
                    end
                    else
                    begin
                        cmd.append      = 1'b1;
                        cmd.resp_status = STS_FREED;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ira_dpath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ira_dpath
// Datapath: request capture, fresh counter, range ring storage and pointers,
// comparators and the output register.
// -----------------------------------------------------------------------------
module ira_dpath
    import ira_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ID_BITS-1:0] s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               cfg_we,
    input  logic [ID_BITS-1:0] cfg_wdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ID_BITS-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    input  ira_cmd_t           cmd,
    output ira_stat_t          stat
);

    func_t   func_reg;
    id_t     id_reg;
    id_t     limit_reg;
    id_t     fresh_reg;
    slot_t   head_reg;
    count_t  count_reg;
    count_t  idx_reg;
    id_t     rd_first_reg;
    id_t     rd_last_reg;
    logic    m_valid_reg;
    status_t m_status_reg;
    id_t     m_granted_reg;

    id_t     first_mem [RANGE_SLOTS];
    id_t     last_mem  [RANGE_SLOTS];

    slot_t   scan_slot;
    slot_t   tail_slot;
    logic    has_above;
    logic    has_below;
    id_t     id_plus;
    id_t     id_minus;
    id_t     grant_val;

    assign scan_slot = slot_add(head_reg, idx_reg);
    assign tail_slot = slot_add(head_reg, count_reg);
    assign has_above = (id_reg != '1);
    assign has_below = (id_reg != '0);
    assign id_plus   = id_reg + ID_BITS'(1);
    assign id_minus  = id_reg - ID_BITS'(1);

    assign stat.func        = func_reg;
    assign stat.out_free    = !m_valid_reg || m_tready;
    assign stat.ring_empty  = (count_reg == '0);
    assign stat.ring_full   = (count_reg == COUNT_BITS'(RANGE_SLOTS));
    assign stat.at_limit    = (fresh_reg == limit_reg);
    assign stat.lower_hit   = has_above && (fresh_reg == id_plus);
    assign stat.head_single = (rd_first_reg >= rd_last_reg);
    assign stat.match_down  = has_above && (rd_first_reg == id_plus);
    assign stat.match_up    = has_below && (rd_last_reg == id_minus);
    assign stat.scan_end    = ((idx_reg + COUNT_BITS'(1)) == count_reg);

    // request, limit and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '1;
            fresh_reg <= ID_BITS'(1);
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.fresh_inc)
            begin
                fresh_reg <= fresh_reg + ID_BITS'(1);
            end
            else if (cmd.fresh_lower)
            begin
                fresh_reg <= id_reg;
            end
            if (cmd.pop)
            begin
                head_reg  <= slot_add(head_reg, COUNT_BITS'(1));
                count_reg <= count_reg - COUNT_BITS'(1);
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(s_tuser[0]);
            id_reg   <= s_tdata;
        end
    end

    // range ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_first_reg <= first_mem[scan_slot];
            rd_last_reg  <= last_mem[scan_slot];
        end
        if (cmd.append)
        begin
            first_mem[tail_slot] <= id_reg;
            last_mem[tail_slot]  <= id_reg;
        end
        else
        begin
            if (cmd.bump)
            begin
                first_mem[scan_slot] <= rd_first_reg + ID_BITS'(1);
            end
            else if (cmd.grow_down)
            begin
                first_mem[scan_slot] <= id_reg;
            end
            if (cmd.grow_up)
            begin
                last_mem[scan_slot] <= id_reg;
            end
        end
    end

    // output register
    always_comb
    begin
        if (cmd.resp_status != STS_ALLOCATED)
        begin
            grant_val = '0;
        end
        else if (cmd.grant_ring)
        begin
            grant_val = rd_first_reg;
        end
        else
        begin
            grant_val = fresh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.resp)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            m_status_reg  <= cmd.resp_status;
            m_granted_reg <= grant_val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_granted_reg;
    assign m_tuser  = m_status_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(RANGE_SLOTS))
        else $error("range count past ring size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg != COUNT_BITS'(RANGE_SLOTS)))
        else $error("append into full ring");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.bump) |-> (count_reg != '0))
        else $error("oldest range taken from empty ring");

    a_resp_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp |-> (!m_valid_reg || m_tready))
        else $error("result overwrites an untaken result");

    a_scan_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.grow_down || cmd.grow_up) |-> (idx_reg < count_reg))
        else $error("range grown outside the ring");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for id_range_allocator. A queue-fed driver sends
// allocate/free requests with random gaps, and a monitor takes results with
// random stalls. Every accepted request runs through a local allocator model,
// and each result is compared against the oldest owed reply. The id_limit
// register is rewritten between phases, only while the block is drained.
// -----------------------------------------------------------------------------
module tb_top;
    import ira_pkg::*;

    localparam int   QUIET_LIMIT    = 2000;  // cycles with no transfer before giving up
    localparam int   TAIL_CYCLES    = 40;    // covers the longest free scan
    localparam int   RANDOM_PHASES  = 6;
    localparam int   PHASE_REQUESTS = 200;
    localparam int   PAST_LIMIT_RUN = 60;
    localparam int   PRINT_CAP      = 100;
    localparam id_t  ID_MAX         = '1;

    // one request as it travels on s_tuser / s_tdata
    typedef struct packed {
        func_t func;
        id_t   value;
    } request_t;

    // one result as it travels on m_tuser / m_tdata
    typedef struct packed {
        status_t status;
        id_t     granted;
    } reply_t;

    // allocator state: fresh counter, free-range ring and the limit register
    typedef struct packed {
        id_t                   limit;
        id_t                   counter;
        id_t [RANGE_SLOTS-1:0] lo;
        id_t [RANGE_SLOTS-1:0] hi;
        slot_t                 head;
        count_t                used;
    } pool_t;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   s_tvalid  = 1'b0;
    logic   s_tready;
    id_t    s_tdata   = '0;
    logic   [0:0] s_tuser = '0;
    logic   m_tvalid;
    logic   m_tready  = 1'b0;
    id_t    m_tdata;
    logic   [1:0] m_tuser;
    logic   cfg_we    = 1'b0;
    id_t    cfg_wdata = '0;

    // live_pool follows the block transfer by transfer; plan_pool runs ahead
    // while requests are generated so frees can target IDs really held
    pool_t    live_pool;
    pool_t    plan_pool;
    request_t request_backlog[$];
    reply_t   owed_replies[$];
    id_t      held_ids[$];

    int requests_issued = 0;
    int requests_taken  = 0;
    int mismatch_count  = 0;
    int send_gap_max    = 8;
    int recv_stall_max  = 8;
    int gap_left        = 0;
    int stall_left      = 0;
    int stall_draw      = 0;
    int quiet_cycles    = 0;

    request_t taken_req;
    request_t next_req;
    reply_t   owed;
    reply_t   want;
    reply_t   got;

    id_range_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] free_value
        .s_tuser   (s_tuser),     // [0] func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] granted
        .m_tuser   (m_tuser),     // [1:0] status
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Allocator model: one request in, one reply out, state updated in place.
    function automatic reply_t allocator_step(inout pool_t p, input request_t rq);
        reply_t r;
        slot_t  s;
        logic   found;
        logic   has_above;
        logic   has_below;
        int     i;
        r.status  = STS_FREED;
        r.granted = '0;
        if (rq.func == FUNC_ALLOC)
        begin
            if (p.used != '0)
            begin
                // oldest range first; drop it when its last ID goes out
                s         = p.head;
                r.status  = STS_ALLOCATED;
                r.granted = p.lo[s];
                if (p.lo[s] >= p.hi[s])
                begin
                    p.head = slot_t'((int'(p.head) + 1) % RANGE_SLOTS);
                    p.used = p.used - 1'b1;
                end
                else
                begin
                    p.lo[s] = p.lo[s] + 1'b1;
                end
            end
            else if (p.counter == p.limit)
            begin
                r.status = STS_ALLOC_FAIL;
            end
            else
            begin
                r.status  = STS_ALLOCATED;
                r.granted = p.counter;
                p.counter = p.counter + 1'b1;   // wraps past the top ID
            end
        end
        else
        begin
            // neighbour tests never wrap around the ID space
            has_above = (rq.value != ID_MAX);
            has_below = (rq.value != '0);
            found     = 1'b0;
            if (has_above && p.counter == id_t'(rq.value + 1'b1))
            begin
                p.counter = rq.value;
                found     = 1'b1;
            end
            for (i = 0; i < int'(p.used) && !found; i++)
            begin
                s = slot_t'((int'(p.head) + i) % RANGE_SLOTS);
                if (has_above && p.lo[s] == id_t'(rq.value + 1'b1))
                begin
                    p.lo[s] = rq.value;
                    found   = 1'b1;
                end
                else if (has_below && p.hi[s] == id_t'(rq.value - 1'b1))
                begin
                    p.hi[s] = rq.value;
                    found   = 1'b1;
                end
            end
            if (!found)
            begin
                if (p.used == count_t'(RANGE_SLOTS))
                begin
                    r.status = STS_FREE_DROP;
                end
                else
                begin
                    s       = slot_t'((int'(p.head) + int'(p.used)) % RANGE_SLOTS);
                    p.lo[s] = rq.value;
                    p.hi[s] = rq.value;
                    p.used  = p.used + 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Queue one request; the planning model tracks which IDs are held.
    task automatic queue_request(input func_t f, input id_t v, output reply_t r);
        request_t rq;
        rq.func  = f;
        rq.value = v;
        r = allocator_step(plan_pool, rq);
        if (r.status == STS_ALLOCATED)
        begin
            held_ids.push_back(r.granted);
        end
        request_backlog.push_back(rq);
        requests_issued++;
    endtask

    // Block idle: every request taken and every reply delivered.
    task automatic wait_drained();
        while (requests_taken != requests_issued || owed_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic set_limit(input id_t v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        plan_pool.limit = v;
        live_pool.limit = v;
    endtask

    // -------------------------------------------------------------------------
    // Request driver. On each accepted transfer the model is stepped and the
    // reply is owed. A gap drawn per request holds tvalid low after it.
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                taken_req.func  = func_t'(s_tuser[0]);
                taken_req.value = s_tdata;
                owed = allocator_step(live_pool, taken_req);
                owed_replies.push_back(owed);
                requests_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    s_tuser  <= next_req.func;
                    s_tdata  <= next_req.value;
                    s_tvalid <= 1'b1;
                    gap_left <= $urandom_range(0, send_gap_max);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Result monitor. Each transfer is checked against the oldest owed reply,
    // then a stall length is drawn and tready is held low while it counts down.
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status  = status_t'(m_tuser);
                got.granted = m_tdata;
                if (owed_replies.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status %0d granted %0d",
                                              got.status, got.granted));
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (got.status != want.status)
                    begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    end
                    if (got.granted != want.granted)
                    begin
                        report_mismatch($sformatf("granted %0d, want %0d",
                                                  got.granted, want.granted));
                    end
                end
                stall_draw = $urandom_range(0, recv_stall_max);
                stall_left <= stall_draw;
                m_tready   <= (stall_draw == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus: directed corner cases, random phases under several limits,
    // and a run of allocates with the limit set below the counter.
    // -------------------------------------------------------------------------
    initial
    begin
        reply_t r;
        int     phase;
        int     n;
        int     k;
        int     pick;
        int     fill_n;
        id_t    v;
        id_t    lim;
        id_t    last_freed;

        live_pool         = '0;
        live_pool.limit   = ID_MAX;
        live_pool.counter = id_t'(1);
        plan_pool         = live_pool;
        last_freed        = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset limit
        queue_request(FUNC_ALLOC, '0, r);           // counter grant
        queue_request(FUNC_FREE, id_t'(1), r);      // just below counter: lowers it
        queue_request(FUNC_FREE, '0, r);            // zero with counter 1: counter to 0
        queue_request(FUNC_ALLOC, '0, r);           // so 0 is granted
        queue_request(FUNC_ALLOC, ID_MAX, r);       // free_value ignored on allocate
        queue_request(FUNC_FREE, ID_MAX, r);        // top ID: no upper neighbour
        queue_request(FUNC_FREE, '0, r);            // zero: no lower neighbour
        queue_request(FUNC_FREE, ID_MAX - 1'b1, r); // grows the top range down
        queue_request(FUNC_FREE, id_t'(1), r);      // counter lowered again
        queue_request(FUNC_FREE, id_t'(5), r);      // new one-ID range
        queue_request(FUNC_FREE, id_t'(6), r);      // grows that range up
        queue_request(FUNC_FREE, id_t'(5), r);      // double free, no detection
        fill_n = 0;
        while (plan_pool.used < count_t'(RANGE_SLOTS))
        begin
            queue_request(FUNC_FREE, id_t'(1000 + 10 * fill_n), r);
            fill_n++;
        end
        queue_request(FUNC_FREE, id_t'(3000), r);   // ring full: dropped

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0, 3:    lim = ID_MAX;
                2:       lim = id_t'(1);
                4:       lim = id_t'($urandom_range(1, 65535));
                default: lim = plan_pool.counter + id_t'($urandom_range(4, 40));
            endcase
            if (lim == '0)
            begin
                lim = id_t'(1);
            end
            // phases 1 and 4 have a steady sender, phases 2 and 5 a steady receiver
            set_limit(lim);
            send_gap_max   = (phase % 3 == 1) ? 0 : 8;
            recv_stall_max = (phase % 3 == 2) ? 0 : 8;

            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 48 || (pick < 88 && held_ids.size() == 0))
                begin
                    queue_request(FUNC_ALLOC, id_t'($urandom()), r);
                end
                else if (pick < 88)
                begin
                    // return an ID that is really out
                    k = $urandom_range(0, held_ids.size() - 1);
                    v = held_ids[k];
                    held_ids[k] = held_ids[held_ids.size() - 1];
                    void'(held_ids.pop_back());
                    queue_request(FUNC_FREE, v, r);
                    last_freed = v;
                end
                else
                begin
                    // noise: stray IDs, edges, near the counter, double frees
                    case ($urandom_range(0, 3))
                        0:       v = id_t'($urandom());
                        1:       v = $urandom_range(0, 1) ? ID_MAX : '0;
                        2:       v = plan_pool.counter + id_t'($urandom_range(0, 3)) - 1'b1;
                        default: v = last_freed;
                    endcase
                    queue_request(FUNC_FREE, v, r);
                end
            end

            if (phase == 2)
            begin
                // Limit one below the counter: allocation keeps counting
                // past the limit instead of failing.
                wait_drained();
                lim = (plan_pool.counter >= id_t'(2)) ? plan_pool.counter - 1'b1 : ID_MAX;
                set_limit(lim);
                send_gap_max   = 0;
                recv_stall_max = 0;
                for (n = 0; n < PAST_LIMIT_RUN; n++)
                begin
                    queue_request(FUNC_ALLOC, '0, r);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
